// ===== hw/rtl/lgss_pkg.sv =====
// Package for the least-greater successor set engine.
// Holds the store sizing, controller state encoding and controller/datapath structs.
// No dependencies.
`timescale 1ns / 1ps

package lgss_pkg;

	localparam int CAPACITY = 64;
	localparam int DATA_W   = 32;
	localparam int ADDR_W   = $clog2(CAPACITY);
	localparam int CNT_W    = $clog2(CAPACITY + 1);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_DONE
	} lgss_state_t;

	// controller to datapath
	typedef struct packed {
		logic load;    // take a new item
		logic issue;   // read the next stored entry
		logic finish;  // write the result, store the value
	} lgss_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic             issue_left;  // entries not yet read
		logic             cmp_busy;    // a read is still being compared
		logic             out_free;    // result register can take a new result
		logic [CNT_W-1:0] count;       // entries held in the store
	} lgss_sts_t;

endpackage

// ===== hw/rtl/lgss_ctrl.sv =====
// Controller of the least-greater successor set engine.
// Sequences accept, store scan and result write-back; uses lgss_pkg.
`timescale 1ns / 1ps

module lgss_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              s_tvalid,
	output logic              s_tready,
	input  lgss_pkg::lgss_sts_t sts,
	output lgss_pkg::lgss_cmd_t cmd
);
	import lgss_pkg::*;

	lgss_state_t state_q;
	lgss_state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d    = state_q;
		s_tready   = 1'b0;
		cmd        = '0;
		unique case (state_q)
			ST_IDLE: begin
				s_tready = 1'b1;
				if (s_tvalid) begin
					cmd.load = 1'b1;
					state_d  = ST_SCAN;
				end
			end
			ST_SCAN: begin
				cmd.issue = sts.issue_left;
				// leave once every entry has been read and compared
				if (!sts.issue_left && !sts.cmp_busy) begin
					state_d = ST_DONE;
				end
			end
			ST_DONE: begin
				// hold until the previous result has been transferred
				if (sts.out_free) begin
					cmd.finish = 1'b1;
					state_d    = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

endmodule

// ===== hw/rtl/lgss_dp.sv =====
// Datapath of the least-greater successor set engine.
// Value store memory, scan address counter, signed compare and result register; uses lgss_pkg.
`timescale 1ns / 1ps

module lgss_dp (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic [lgss_pkg::DATA_W-1:0]  in_value,
	input  logic                         in_start,
	input  lgss_pkg::lgss_cmd_t          cmd,
	output lgss_pkg::lgss_sts_t          sts,
	output logic                         out_valid,
	input  logic                         out_ready,
	output logic [lgss_pkg::DATA_W-1:0]  out_successor,
	output logic                         out_found,
	output logic                         out_dropped
);
	import lgss_pkg::*;

	logic [DATA_W-1:0] mem [CAPACITY];

	logic [DATA_W-1:0] value_q;
	logic [CNT_W-1:0]  count_q;
	logic [CNT_W-1:0]  rd_idx_q;
	logic [DATA_W-1:0] rd_data_s1;
	logic              cmp_vld_s1;
	logic [DATA_W-1:0] best_q;
	logic              hit_q;
	logic              out_valid_q;
	logic [DATA_W-1:0] succ_q;
	logic              found_q;
	logic              drop_q;
	logic              full;
	logic              better;

	assign full   = (count_q == CNT_W'(CAPACITY));
	assign better = ($signed(rd_data_s1) > $signed(value_q)) &&
		(!hit_q || ($signed(rd_data_s1) < $signed(best_q)));

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			rd_idx_q    <= '0;
			cmp_vld_s1  <= 1'b0;
			hit_q       <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			cmp_vld_s1 <= cmd.issue;
			if (cmd.load) begin
				rd_idx_q <= '0;
				hit_q    <= 1'b0;
				if (in_start) begin
					count_q <= '0;
				end
			end else if (cmd.issue) begin
				rd_idx_q <= rd_idx_q + CNT_W'(1);
			end
			if (cmp_vld_s1 && better) begin
				hit_q <= 1'b1;
			end
			if (cmd.finish && !full) begin
				count_q <= count_q + CNT_W'(1);
			end
			if (cmd.finish) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// payload
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			value_q <= in_value;
		end
		if (cmp_vld_s1 && better) begin
			best_q <= rd_data_s1;
		end
		if (cmd.finish) begin
			succ_q  <= hit_q ? best_q : '1;
			found_q <= hit_q;
			drop_q  <= full;
		end
	end

	// store: one write, one registered read a cycle
	always_ff @(posedge clk) begin
		if (cmd.finish && !full) begin
			mem[count_q[ADDR_W-1:0]] <= value_q;
		end
		if (cmd.issue) begin
			rd_data_s1 <= mem[rd_idx_q[ADDR_W-1:0]];
		end
	end

	assign sts.issue_left = (rd_idx_q != count_q);
	assign sts.cmp_busy   = cmp_vld_s1;
	assign sts.out_free   = !out_valid_q || out_ready;
	assign sts.count      = count_q;

	assign out_valid     = out_valid_q;
	assign out_successor = succ_q;
	assign out_found     = found_q;
	assign out_dropped   = drop_q;

endmodule

// ===== hw/rtl/least_greater_successor_set.sv =====
// Top level of the least-greater successor set engine.
// Joins lgss_ctrl and lgss_dp; uses lgss_pkg.
//
//  channel   dir  data                  side band
//  s_*       in   value (32, signed)    tuser: start_req
//  m_*       out  successor (32, sgn)   tuser: found, dropped
//
// An item runs from one accept to the next through accept, the scan of the store memory
// (count being the entries already stored, 0 to 64) through its one read port at one
// entry a cycle, the drain of the last compare, and write-back.
// Reset clears the entry count and all control; the memory itself is not cleared.
// A stalled result waits in the output register while the next item is taken and
// scanned; write-back of that item holds until the result has been transferred.
`timescale 1ns / 1ps

module least_greater_successor_set (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [31:0] s_tdata,   // [31:0] value
	input  logic        s_tuser,   // [0] start_req
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [31:0] m_tdata,   // [31:0] successor
	output logic [1:0]  m_tuser    // [0] found, [1] dropped
);
	import lgss_pkg::*;

	lgss_cmd_t cmd;
	lgss_sts_t sts;
	logic      found;
	logic      dropped;

	lgss_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.sts      (sts),
		.cmd      (cmd)
	);

	lgss_dp u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_value      (s_tdata),
		.in_start      (s_tuser),
		.cmd           (cmd),
		.sts           (sts),
		.out_valid     (m_tvalid),
		.out_ready     (m_tready),
		.out_successor (m_tdata),
		.out_found     (found),
		.out_dropped   (dropped)
	);

	assign m_tuser = {dropped, found};

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		sts.count <= CNT_W'(CAPACITY))
		else $error("store count beyond capacity");

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.finish |-> (!m_tvalid || m_tready))
		else $error("result written over an untransferred result");

	a_miss_sentinel: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && !m_tuser[0]) |-> (m_tdata == '1))
		else $error("miss without all-ones successor");

	a_no_accept_in_scan: assert property (@(posedge clk) disable iff (!arst_n)
		!(s_tready && (cmd.issue || cmd.finish)))
		else $error("input accepted while an item is in progress");

endmodule
